// ----- rtl/ppu_pkg.sv -----
// types and constants shared by the particle pool blocks
`timescale 1ns / 1ps

package ppu_pkg;

    localparam logic       KIND_SPAWN = 1'b0;
    localparam logic       KIND_TICK  = 1'b1;

    localparam logic [1:0] STATUS_SPAWNED = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_REPORT  = 2'd2;

    localparam logic [1:0] REG_ACCEL_X = 2'd0;
    localparam logic [1:0] REG_ACCEL_Y = 2'd1;
    localparam logic [1:0] REG_ACCEL_Z = 2'd2;

    // fade step is DIVIDEND / lifespan, one quotient bit per cycle
    localparam logic [15:0] DIVIDEND  = 16'd32768;
    localparam int          DIV_STEPS = 16;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] spawn_pos_x;
        logic signed [31:0] spawn_pos_y;
        logic signed [31:0] spawn_pos_z;
        logic signed [31:0] spawn_vel_x;
        logic signed [31:0] spawn_vel_y;
        logic signed [31:0] spawn_vel_z;
        logic [15:0]        spawn_alpha;
        logic [15:0]        spawn_life;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         slot;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic [15:0]        out_alpha;
        logic               last;
    } out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } accel_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [15:0] alpha;
        logic [16:0] life;
        logic [15:0] fade_len;
        logic [15:0] fade_step;
    } slot_t;

    typedef struct packed {
        logic take_in;
        logic idx_clr;
        logic idx_inc;
        logic div_start;
        logic rem_load;
        logic mem_rd;
        logic spawn_wr;
        logic full_res;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic used_cur;
        logic idx_last;
        logic div_busy;
        logic life_zero;
        logic out_free;
        logic live_zero;
        logic rem_zero;
        logic rem_one;
    } sts_t;

endpackage

// ----- rtl/ppu_stream_if.sv -----
// valid/ready stream channel carrying one payload struct
`timescale 1ns / 1ps

interface ppu_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ppu_div.sv -----
// restoring divider for the fade step, one quotient bit per cycle
`timescale 1ns / 1ps

module ppu_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [15:0] quot
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [16:0] rem_reg;
    logic [15:0] dvd_reg;
    logic [15:0] quot_reg;
    logic [15:0] dsr_reg;
    logic [16:0] trial;

    assign trial = {rem_reg[15:0], dvd_reg[15]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'(ppu_pkg::DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            dvd_reg  <= ppu_pkg::DIVIDEND;
            quot_reg <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[14:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_reg  <= trial - {1'b0, dsr_reg};
                quot_reg <= {quot_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[14:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/ppu_dp.sv -----
// datapath: slot memory, valid bits, counters, update arithmetic, result register
`timescale 1ns / 1ps

module ppu_dp #(
    parameter int POOL_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ppu_pkg::cmd_t   cmd,
    output ppu_pkg::sts_t   sts,
    input  ppu_pkg::in_t    in_data,
    input  ppu_pkg::accel_t accel,
    output ppu_pkg::out_t   out_data,
    output logic            out_valid,
    input  logic            out_ready
);

    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);

    ppu_pkg::in_t       in_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [POOL_DEPTH-1:0] used_reg;
    logic [CNT_W-1:0]   live_reg;
    logic [CNT_W-1:0]   rem_reg;
    ppu_pkg::slot_t     mem [POOL_DEPTH];
    ppu_pkg::slot_t     rd_reg;
    ppu_pkg::slot_t     upd;
    ppu_pkg::slot_t     spawn_w;
    ppu_pkg::slot_t     wr_data;
    logic               wr_en;
    logic               dies;
    logic [16:0]        life_m1;
    ppu_pkg::out_t      out_reg;
    logic               out_valid_reg;
    logic               div_busy;
    logic [15:0]        div_quot;
    logic               life_zero;

    ppu_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .divisor (in_reg.spawn_life),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    assign life_zero = (in_reg.spawn_life == 16'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            in_reg <= in_data;
        end
    end

    // update of the slot just read
    always_comb
    begin
        life_m1 = rd_reg.life - 17'd1;
        dies    = (rd_reg.life <= 17'd1);
        upd       = rd_reg;
        upd.life  = life_m1;
        upd.pos_x = rd_reg.pos_x + rd_reg.vel_x;
        upd.pos_y = rd_reg.pos_y + rd_reg.vel_y;
        upd.pos_z = rd_reg.pos_z + rd_reg.vel_z;
        upd.vel_x = rd_reg.vel_x + accel.x;
        upd.vel_y = rd_reg.vel_y + accel.y;
        upd.vel_z = rd_reg.vel_z + accel.z;
        if (life_m1 < {1'b0, rd_reg.fade_len})
        begin
            if (rd_reg.alpha > rd_reg.fade_step)
            begin
                upd.alpha = rd_reg.alpha - rd_reg.fade_step;
            end
            else
            begin
                upd.alpha = 16'd0;
            end
        end
    end

    always_comb
    begin
        spawn_w.pos_x     = in_reg.spawn_pos_x;
        spawn_w.pos_y     = in_reg.spawn_pos_y;
        spawn_w.pos_z     = in_reg.spawn_pos_z;
        spawn_w.vel_x     = in_reg.spawn_vel_x;
        spawn_w.vel_y     = in_reg.spawn_vel_y;
        spawn_w.vel_z     = in_reg.spawn_vel_z;
        spawn_w.alpha     = in_reg.spawn_alpha;
        spawn_w.life      = {1'b0, in_reg.spawn_life};
        spawn_w.fade_len  = in_reg.spawn_life;
        spawn_w.fade_step = life_zero ? 16'd0 : div_quot;
    end

    assign wr_en   = cmd.spawn_wr || (cmd.emit && !dies);
    assign wr_data = cmd.spawn_wr ? spawn_w : upd;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            live_reg <= '0;
            rem_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.spawn_wr)
            begin
                used_reg[idx_reg] <= 1'b1;
                live_reg          <= live_reg + CNT_W'(1);
            end
            else if (cmd.emit && dies)
            begin
                used_reg[idx_reg] <= 1'b0;
                live_reg          <= live_reg - CNT_W'(1);
            end
            if (cmd.rem_load)
            begin
                rem_reg <= live_reg;
            end
            else if (cmd.emit)
            begin
                rem_reg <= rem_reg - CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.spawn_wr || cmd.full_res || cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.spawn_wr || cmd.full_res)
        begin
            out_reg.status    <= cmd.spawn_wr ? ppu_pkg::STATUS_SPAWNED : ppu_pkg::STATUS_FULL;
            out_reg.slot      <= cmd.spawn_wr ? 6'(idx_reg) : 6'd0;
            out_reg.out_pos_x <= '0;
            out_reg.out_pos_y <= '0;
            out_reg.out_pos_z <= '0;
            out_reg.out_alpha <= '0;
            out_reg.last      <= 1'b1;
        end
        else if (cmd.emit)
        begin
            out_reg.status    <= ppu_pkg::STATUS_REPORT;
            out_reg.slot      <= 6'(idx_reg);
            out_reg.out_pos_x <= rd_reg.pos_x;
            out_reg.out_pos_y <= rd_reg.pos_y;
            out_reg.out_pos_z <= rd_reg.pos_z;
            out_reg.out_alpha <= rd_reg.alpha;
            out_reg.last      <= (rem_reg == CNT_W'(1));
        end
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        sts.kind      = in_reg.kind;
        sts.used_cur  = used_reg[idx_reg];
        sts.idx_last  = (idx_reg == IDX_W'(POOL_DEPTH - 1));
        sts.div_busy  = div_busy;
        sts.life_zero = life_zero;
        sts.out_free  = !out_valid_reg || out_ready;
        sts.live_zero = (live_reg == '0);
        sts.rem_zero  = (rem_reg == '0);
        sts.rem_one   = (rem_reg == CNT_W'(1));
    end

endmodule

// ----- rtl/ppu_ctrl.sv -----
// controller state machine sequencing spawn and tick items
`timescale 1ns / 1ps

module ppu_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ppu_pkg::sts_t sts,
    output ppu_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SFIND = 4'd2;
    localparam logic [3:0] S_SDIV  = 4'd3;
    localparam logic [3:0] S_SWR   = 4'd4;
    localparam logic [3:0] S_FULL  = 4'd5;
    localparam logic [3:0] S_TSCAN = 4'd6;
    localparam logic [3:0] S_TREAD = 4'd7;
    localparam logic [3:0] S_TEMIT = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.kind == ppu_pkg::KIND_SPAWN)
                begin
                    state_next = S_SFIND;
                end
                else
                begin
                    cmd.rem_load = 1'b1;
                    state_next   = sts.live_zero ? S_IDLE : S_TSCAN;
                end
            end
            S_SFIND:
            begin
                if (!sts.used_cur)
                begin
                    if (sts.life_zero)
                    begin
                        state_next = S_SWR;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_SDIV;
                    end
                end
                else if (sts.idx_last)
                begin
                    state_next = S_FULL;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_SWR;
                end
            end
            S_SWR:
            begin
                if (sts.out_free)
                begin
                    cmd.spawn_wr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FULL:
            begin
                if (sts.out_free)
                begin
                    cmd.full_res = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_TSCAN:
            begin
                if (sts.rem_zero)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.used_cur)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_TREAD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_TREAD:
            begin
                state_next = S_TEMIT;
            end
            S_TEMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.rem_one)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_TSCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/particle_pool_update.sv -----
// top level of the particle pool: channels, register port, controller and datapath
`timescale 1ns / 1ps

// A pool of POOL_DEPTH particle slots. A spawn beat takes the lowest free
// slot (found by a scan of one slot per cycle), computes the fade step
// 32768 / lifespan in a restoring divider (zero, with no divide, for a
// lifespan of zero) and stores the particle; it answers with one result
// beat, or a pool-full beat when no slot is free. A tick beat walks the
// slots in index order: a free slot is only scanned, a live slot goes
// through scan, memory read, and report with write back, and the walk
// stops after the last live slot; an empty pool tick ends with no result.
// The per-slot state sits in a single-port-write, registered-read memory,
// hence the separate memory read step. Accelerations are to be written
// over the register port only while the block is idle; the block itself
// does not enforce this. Results leave through an output register, so
// the last result may still wait while the next input beat is taken.
module particle_pool_update #(
    parameter int POOL_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    ppu_stream_if.sink   in_ch,
    ppu_stream_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ppu_pkg::cmd_t   cmd;
    ppu_pkg::sts_t   sts;
    ppu_pkg::accel_t accel_reg;
    logic            cfg_wr;

    // acceleration registers, one word each at 4-byte spacing
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                ppu_pkg::REG_ACCEL_X: accel_reg.x <= pwdata;
                ppu_pkg::REG_ACCEL_Y: accel_reg.y <= pwdata;
                ppu_pkg::REG_ACCEL_Z: accel_reg.z <= pwdata;
                default:              accel_reg   <= accel_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ppu_pkg::REG_ACCEL_X: prdata = accel_reg.x;
            ppu_pkg::REG_ACCEL_Y: prdata = accel_reg.y;
            ppu_pkg::REG_ACCEL_Z: prdata = accel_reg.z;
            default:              prdata = 32'd0;
        endcase
    end

    // sequencing of spawn search, divide, and the tick walk
    ppu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // slot memory, counters and result register
    ppu_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_ch.data),
        .accel     (accel_reg),
        .out_data  (out_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready)
    );

    // one item at a time: no new beat right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken while an item is in progress");

    // a pool-full beat names slot zero and closes its item
    a_full_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.status == ppu_pkg::STATUS_FULL)
            |-> (out_ch.data.slot == 6'd0 && out_ch.data.last))
        else $error("pool-full beat malformed");

    // spawn results always close their item
    a_spawn_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.status == ppu_pkg::STATUS_SPAWNED)
            |-> out_ch.data.last)
        else $error("spawn beat without last");

endmodule

// ----- dv/ppu_checker.sv -----
// particle pool checker: watches both channels, predicts results and compares them
`timescale 1ns / 1ps

module ppu_checker #(
    parameter int POOL_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  ppu_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  ppu_pkg::out_t out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output int            fail_count,
    output int            pending
);

    ppu_pkg::accel_t cur_accel;
    logic            live [POOL_DEPTH];
    ppu_pkg::slot_t  pool [POOL_DEPTH];
    ppu_pkg::out_t   expected_beats[$];

    assign pending = expected_beats.size();

    // advance the pool by one input beat, queueing the beats it causes
    task automatic apply_input(input ppu_pkg::in_t item);
        int            idx;
        int            n;
        ppu_pkg::out_t r;
        logic [15:0]   step;
        begin
            if (item.kind == ppu_pkg::KIND_SPAWN)
            begin
                idx = -1;
                for (int i = POOL_DEPTH - 1; i >= 0; i--)
                    if (!live[i]) idx = i;
                r = '0;
                r.last = 1'b1;
                if (idx < 0)
                begin
                    r.status = ppu_pkg::STATUS_FULL;
                end
                else
                begin
                    step = (item.spawn_life == 16'd0) ? 16'd0
                                                      : 16'(32768 / item.spawn_life);
                    live[idx] = 1'b1;
                    pool[idx] = '{pos_x: item.spawn_pos_x, pos_y: item.spawn_pos_y,
                                  pos_z: item.spawn_pos_z, vel_x: item.spawn_vel_x,
                                  vel_y: item.spawn_vel_y, vel_z: item.spawn_vel_z,
                                  alpha: item.spawn_alpha, life: {1'b0, item.spawn_life},
                                  fade_len: item.spawn_life, fade_step: step};
                    r.status = ppu_pkg::STATUS_SPAWNED;
                    r.slot   = 6'(idx);
                end
                expected_beats.push_back(r);
            end
            else
            begin
                n = 0;
                for (int i = 0; i < POOL_DEPTH; i++)
                begin
                    if (!live[i]) continue;
                    r = '0;
                    r.status    = ppu_pkg::STATUS_REPORT;
                    r.slot      = 6'(i);
                    r.out_pos_x = pool[i].pos_x;
                    r.out_pos_y = pool[i].pos_y;
                    r.out_pos_z = pool[i].pos_z;
                    r.out_alpha = pool[i].alpha;
                    expected_beats.push_back(r);
                    n++;
                    if (pool[i].life <= 17'd1)
                    begin
                        pool[i].life = '0;
                        live[i] = 1'b0;
                    end
                    else
                    begin
                        pool[i].life  = pool[i].life - 17'd1;
                        pool[i].pos_x = pool[i].pos_x + pool[i].vel_x;
                        pool[i].pos_y = pool[i].pos_y + pool[i].vel_y;
                        pool[i].pos_z = pool[i].pos_z + pool[i].vel_z;
                        pool[i].vel_x = pool[i].vel_x + cur_accel.x;
                        pool[i].vel_y = pool[i].vel_y + cur_accel.y;
                        pool[i].vel_z = pool[i].vel_z + cur_accel.z;
                        if (pool[i].life < {1'b0, pool[i].fade_len})
                            pool[i].alpha = (pool[i].alpha > pool[i].fade_step)
                                ? pool[i].alpha - pool[i].fade_step : 16'd0;
                    end
                end
                // the final report of a tick carries last
                if (n > 0) expected_beats[$].last = 1'b1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ppu_pkg::out_t exp_beat;
        if (!rst_n)
        begin
            fail_count = 0;
            cur_accel  = '0;
            expected_beats.delete();
            for (int i = 0; i < POOL_DEPTH; i++) live[i] = 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    ppu_pkg::REG_ACCEL_X: cur_accel.x = pwdata;
                    ppu_pkg::REG_ACCEL_Y: cur_accel.y = pwdata;
                    ppu_pkg::REG_ACCEL_Z: cur_accel.z = pwdata;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected result beat %p", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    exp_beat = expected_beats.pop_front();
                    if (out_data !== exp_beat)
                    begin
                        $display("%0t: result mismatch, expected %p actual %p",
                                 $time, exp_beat, out_data);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready) apply_input(in_data);
        end
    end

endmodule

// ----- dv/tb_particle_pool_update.sv -----
// testbench top: clock, reset, stimulus, register writes and verdict
`timescale 1ns / 1ps

module tb_particle_pool_update;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    // receiver behavior, owned by its own process
    bit          sink_quiet;     // no random stalls in the closing part
    bit          sink_hold;      // long hold-off request
    int          sink_hold_cycles;

    ppu_stream_if #(.payload_t(ppu_pkg::in_t))  in_ch ();
    ppu_stream_if #(.payload_t(ppu_pkg::out_t)) out_ch ();

    particle_pool_update u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ppu_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_data    (in_ch.data),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_data   (out_ch.data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #50ms;
        $display("particle_pool_update regression: fail");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold)
            begin
                out_ch.ready = 1'b0;
                repeat (sink_hold_cycles) @(negedge clk);
                sink_hold = 1'b0;
                out_ch.ready = 1'b1;
            end
            else if (!sink_quiet && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 6);
                out_ch.ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // register write: setup then access phase, only while idle
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        begin
            @(negedge clk);
            psel    = 1'b1;
            penable = 1'b0;
            pwrite  = 1'b1;
            paddr   = {index, 2'b00};
            pwdata  = value;
            @(negedge clk);
            penable = 1'b1;
            @(negedge clk);
            psel    = 1'b0;
            penable = 1'b0;
            pwrite  = 1'b0;
        end
    endtask

    task automatic set_accel(input logic [31:0] ax, input logic [31:0] ay,
                             input logic [31:0] az);
        begin
            write_reg(ppu_pkg::REG_ACCEL_X, ax);
            write_reg(ppu_pkg::REG_ACCEL_Y, ay);
            write_reg(ppu_pkg::REG_ACCEL_Z, az);
        end
    endtask

    // drain everything queued, then allow the longest tail of a walk
    task automatic wait_drained();
        begin
            while (pending != 0) @(negedge clk);
            repeat (3 * 64 + 40) @(negedge clk);
        end
    endtask

    // hand one beat to the block; random sender gaps unless quiet
    task automatic send_beat(input ppu_pkg::in_t item, input bit quiet);
        int gap;
        begin
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 6);
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_ch.valid = 1'b1;
            in_ch.data  = item;
            // ready seen high at the falling edge means the next rising edge takes it
            while (!in_ch.ready) @(negedge clk);
            @(posedge clk);
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // random spawn; lifespans mostly short so slots recycle
    function automatic ppu_pkg::in_t rand_spawn();
        ppu_pkg::in_t s;
        s.kind        = ppu_pkg::KIND_SPAWN;
        s.spawn_pos_x = rand_word();
        s.spawn_pos_y = rand_word();
        s.spawn_pos_z = rand_word();
        s.spawn_vel_x = rand_word();
        s.spawn_vel_y = rand_word();
        s.spawn_vel_z = rand_word();
        case ($urandom_range(0, 3))
            0:       s.spawn_alpha = 16'($urandom());
            default: s.spawn_alpha = 16'($urandom_range(0, 32768));
        endcase
        case ($urandom_range(0, 9))
            0:       s.spawn_life = 16'($urandom());
            1:       s.spawn_life = 16'd0;
            default: s.spawn_life = 16'($urandom_range(1, 12));
        endcase
        return s;
    endfunction

    function automatic ppu_pkg::in_t tick_beat();
        ppu_pkg::in_t t;
        t      = rand_spawn();   // payload is noise on a tick
        t.kind = ppu_pkg::KIND_TICK;
        return t;
    endfunction

    initial
    begin
        ppu_pkg::in_t item;
        bit           quiet;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        sink_quiet = 1'b0;
        sink_hold  = 1'b0;
        sink_hold_cycles = 0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: tick on empty pool, extremes, zero life, alpha above one
        send_beat(tick_beat(), 1'b1);
        set_accel(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        item = rand_spawn();
        item.spawn_pos_x = 32'h7FFF_FFFF; item.spawn_pos_y = 32'h8000_0000;
        item.spawn_pos_z = 32'hFFFF_FFFF; item.spawn_vel_x = 32'h7FFF_FFFF;
        item.spawn_vel_y = 32'h8000_0000; item.spawn_vel_z = 32'hFFFF_FFFF;
        item.spawn_alpha = 16'd32768;     item.spawn_life = 16'd3;
        send_beat(item, 1'b1);
        item.spawn_life = 16'd0;          item.spawn_alpha = 16'hFFFF;
        send_beat(item, 1'b1);
        item.spawn_life = 16'hFFFF;       item.spawn_alpha = 16'd0;
        send_beat(item, 1'b1);
        item.spawn_life = 16'd1;          item.spawn_alpha = 16'd5;
        send_beat(item, 1'b1);
        item.spawn_life = 16'd2;          item.spawn_alpha = 16'd40000;
        send_beat(item, 1'b1);
        for (int k = 0; k < 5; k++) send_beat(tick_beat(), 1'b1);
        wait_drained();

        // fill the pool to overflow; the receiver holds off at the start
        set_accel(32'h0, 32'h0, 32'h0);
        sink_hold_cycles = 400;
        sink_hold = 1'b1;
        for (int k = 0; k < 66; k++)
        begin
            item = rand_spawn();
            item.spawn_life = 16'($urandom_range(1, 4));
            send_beat(item, 1'b0);
        end
        send_beat(tick_beat(), 1'b0);
        // sender pauses until every result is back
        wait_drained();
        set_accel(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
        for (int k = 0; k < 4; k++) send_beat(tick_beat(), 1'b0);
        wait_drained();

        // random phases, each with a fresh acceleration
        for (int phase = 0; phase < 4; phase++)
        begin
            set_accel(rand_word(), rand_word(), rand_word());
            quiet = (phase == 3);
            sink_quiet = quiet;
            for (int k = 0; k < 40; k++)
                send_beat(($urandom_range(0, 2) == 0) ? tick_beat() : rand_spawn(), quiet);
            wait_drained();
        end

        if (fail_count == 0)
            $display("particle_pool_update regression: pass");
        else
            $display("particle_pool_update regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ppu_pkg.sv
rtl/ppu_stream_if.sv
rtl/ppu_div.sv
rtl/ppu_dp.sv
rtl/ppu_ctrl.sv
rtl/particle_pool_update.sv
dv/ppu_checker.sv
dv/tb_particle_pool_update.sv
